[design/tcpsl_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcpsl_pkg
// Shared constants and codes for the TCP header slicer with session tracking.
// ---------------------------------------------------------------------------
package tcpsl_pkg;

  localparam int unsigned ETH_HEADER_BYTES = 14;
  localparam int unsigned MAX_FRAME_BYTES  = 65535;
  localparam int unsigned FIXED_TCP_BYTES  = 20;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned REG_W  = 6;
  localparam int unsigned CIDX_W = 1;

  localparam logic [REG_W-1:0] MIN_IP_RESET  = REG_W'(10);
  localparam logic [REG_W-1:0] MIN_TCP_RESET = REG_W'(20);

  localparam logic [CIDX_W-1:0] CFG_MIN_IP  = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_MIN_TCP = CIDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IP_SHORT  = 2'd1,
    ST_TCP_SHORT = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIR_CLIENT = 2'd0,
    DIR_SERVER = 2'd1,
    DIR_NONE   = 2'd2
  } dir_t;

endpackage

[design/tcp_header_slicer_with_session.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcp_header_slicer_with_session
// Byte-stream Ethernet/IPv4/TCP header field extractor with session matching.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one frame byte per item, with
//   in_last_byte high on the final captured byte of the frame.
//   Result channel (out_valid/out_stall): one item per frame, issued for the
//   final byte, carrying status, header fields, direction, session match and
//   payload length. Bytes that are not final produce no result.
//   Config port: cfg_wr_en writes cfg_wr_data into the register selected by
//   cfg_index (0: minimum IP header bytes, 1: minimum TCP header bytes).
//   Write only while no frame is in flight.
// Pipeline and throughput:
//   An item is accepted into the input register, then the parse logic
//   updates the frame state and loads the result register, which drives
//   out_valid. One byte is taken every cycle while in_stall is low;
//   the rate is set by the single parse stage.
// Reset: synchronous, active low; clears frame state, the recorded session
//   and restores both config registers to their defaults.
// Stall: a result waits in the output register while out_stall is high;
//   non-final bytes keep flowing, a final byte waits in the input register
//   and in_stall rises until the output register frees up.
// ---------------------------------------------------------------------------
module tcp_header_slicer_with_session (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tcpsl_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tcpsl_pkg::REG_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [1:0]                     out_direction,
  output logic                           out_in_session,
  output logic [31:0]                    out_source_address,
  output logic [31:0]                    out_dest_address,
  output logic [15:0]                    out_source_port,
  output logic [15:0]                    out_dest_port,
  output logic [31:0]                    out_sequence_number,
  output logic [31:0]                    out_ack_number,
  output logic [7:0]                     out_tcp_flag_bits,
  output logic [15:0]                    out_window_size,
  output logic [15:0]                    out_payload_length
);
  import tcpsl_pkg::*;

  localparam logic [POS_W-1:0] ETH_POS = POS_W'(ETH_HEADER_BYTES);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] FIX_TCP = POS_W'(FIXED_TCP_BYTES);

  logic [REG_W-1:0] min_ip_r, min_tcp_r;

  logic       s1_valid_r, s1_last_r;
  logic [7:0] s1_data_r;
  logic       s1_adv, s1_load, s1_fin;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       ihl_r, ihl_nxt, ofs_r, ofs_nxt;
  logic [31:0]      h_saddr_r, h_saddr_nxt, h_daddr_r, h_daddr_nxt;
  logic [15:0]      h_sport_r, h_sport_nxt, h_dport_r, h_dport_nxt;
  logic [31:0]      h_seq_r, h_seq_nxt, h_ack_r, h_ack_nxt;
  logic [7:0]       h_flags_r, h_flags_nxt;
  logic [15:0]      h_win_r, h_win_nxt;

  logic        sess_r, sess_nxt;
  logic [31:0] cli_addr_r, cli_addr_nxt, srv_addr_r, srv_addr_nxt;
  logic [15:0] cli_port_r, cli_port_nxt, srv_port_r, srv_port_nxt;

  logic             cap;
  logic [POS_W-1:0] rip, tcp_start, rtcp, ip_bytes, tcp_bytes;
  logic             record, fields;
  status_t          status;
  dir_t             dir;
  logic             match;
  logic [15:0]      payload;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_status_r, o_dir_r;
  logic        o_match_r;
  logic [31:0] o_saddr_r, o_daddr_r, o_seq_r, o_ack_r;
  logic [15:0] o_sport_r, o_dport_r, o_win_r, o_pay_r;
  logic [7:0]  o_flags_r;

  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign s1_load  = in_valid && !in_stall;
  assign s1_fin   = s1_adv && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ip_r  <= MIN_IP_RESET;
      min_tcp_r <= MIN_TCP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_IP:  min_ip_r  <= cfg_wr_data;
        CFG_MIN_TCP: min_tcp_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_comb begin
    cap         = pos_r < MAX_POS;
    pos_nxt     = cap ? pos_r + POS_W'(1) : pos_r;
    ihl_nxt     = (cap && pos_r == ETH_POS) ? s1_data_r[3:0] : ihl_r;
    ofs_nxt     = ofs_r;
    h_saddr_nxt = h_saddr_r;
    h_daddr_nxt = h_daddr_r;
    h_sport_nxt = h_sport_r;
    h_dport_nxt = h_dport_r;
    h_seq_nxt   = h_seq_r;
    h_ack_nxt   = h_ack_r;
    h_flags_nxt = h_flags_r;
    h_win_nxt   = h_win_r;
    rip         = pos_r - ETH_POS;
    tcp_start   = ETH_POS + POS_W'({ihl_nxt, 2'b00});
    rtcp        = pos_r - tcp_start;
    if (cap && pos_r >= ETH_POS) begin
      if (rip inside {[12:15]}) h_saddr_nxt = {h_saddr_r[23:0], s1_data_r};
      if (rip inside {[16:19]}) h_daddr_nxt = {h_daddr_r[23:0], s1_data_r};
    end
    if (cap && pos_r >= tcp_start) begin
      if (rtcp <= POS_W'(1))       h_sport_nxt = {h_sport_r[7:0], s1_data_r};
      else if (rtcp <= POS_W'(3))  h_dport_nxt = {h_dport_r[7:0], s1_data_r};
      else if (rtcp <= POS_W'(7))  h_seq_nxt   = {h_seq_r[23:0], s1_data_r};
      else if (rtcp <= POS_W'(11)) h_ack_nxt   = {h_ack_r[23:0], s1_data_r};
      else if (rtcp == POS_W'(12)) ofs_nxt     = s1_data_r[7:4];
      else if (rtcp == POS_W'(13)) h_flags_nxt = s1_data_r;
      else if (rtcp <= POS_W'(15)) h_win_nxt   = {h_win_r[7:0], s1_data_r};
    end
  end

  always_comb begin
    ip_bytes  = POS_W'({ihl_nxt, 2'b00});
    tcp_bytes = POS_W'({ofs_nxt, 2'b00});
    record    = 1'b0;
    fields    = 1'b0;
    status    = ST_OK;
    if (pos_nxt <= ETH_POS) begin
      status = ST_TRUNC;
    end else if (ip_bytes < POS_W'(min_ip_r)) begin
      status = ST_IP_SHORT;
    end else if (pos_nxt < tcp_start + FIX_TCP) begin
      status = ST_TRUNC;
    end else begin
      record = 1'b1;
      if (tcp_bytes < POS_W'(min_tcp_r)) begin
        status = ST_TCP_SHORT;
        fields = 1'b1;
      end else if (pos_nxt < tcp_start + tcp_bytes) begin
        status = ST_TRUNC;
      end else begin
        status = ST_OK;
        fields = 1'b1;
      end
    end
  end

  always_comb begin
    sess_nxt     = sess_r;
    cli_addr_nxt = cli_addr_r;
    srv_addr_nxt = srv_addr_r;
    cli_port_nxt = cli_port_r;
    srv_port_nxt = srv_port_r;
    if (s1_fin && record && !sess_r) begin
      sess_nxt     = 1'b1;
      cli_addr_nxt = h_saddr_nxt;
      srv_addr_nxt = h_daddr_nxt;
      cli_port_nxt = h_sport_nxt;
      srv_port_nxt = h_dport_nxt;
    end
  end

  always_comb begin
    dir     = DIR_NONE;
    match   = 1'b0;
    payload = 16'd0;
    if (status == ST_OK) begin
      payload = pos_nxt - tcp_start - tcp_bytes;
      if (h_saddr_nxt == cli_addr_nxt && h_sport_nxt == cli_port_nxt) begin
        dir = DIR_CLIENT;
      end else if (h_saddr_nxt == srv_addr_nxt && h_sport_nxt == srv_port_nxt) begin
        dir = DIR_SERVER;
      end
      match = (h_saddr_nxt == cli_addr_nxt && h_sport_nxt == cli_port_nxt &&
               h_daddr_nxt == srv_addr_nxt && h_dport_nxt == srv_port_nxt) ||
              (h_daddr_nxt == cli_addr_nxt && h_dport_nxt == cli_port_nxt &&
               h_saddr_nxt == srv_addr_nxt && h_sport_nxt == srv_port_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || s1_fin) begin
      pos_r     <= '0;
      ihl_r     <= '0;
      ofs_r     <= '0;
      h_saddr_r <= '0;
      h_daddr_r <= '0;
      h_sport_r <= '0;
      h_dport_r <= '0;
      h_seq_r   <= '0;
      h_ack_r   <= '0;
      h_flags_r <= '0;
      h_win_r   <= '0;
    end else if (s1_adv) begin
      pos_r     <= pos_nxt;
      ihl_r     <= ihl_nxt;
      ofs_r     <= ofs_nxt;
      h_saddr_r <= h_saddr_nxt;
      h_daddr_r <= h_daddr_nxt;
      h_sport_r <= h_sport_nxt;
      h_dport_r <= h_dport_nxt;
      h_seq_r   <= h_seq_nxt;
      h_ack_r   <= h_ack_nxt;
      h_flags_r <= h_flags_nxt;
      h_win_r   <= h_win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r     <= 1'b0;
      cli_addr_r <= '0;
      srv_addr_r <= '0;
      cli_port_r <= '0;
      srv_port_r <= '0;
    end else begin
      sess_r     <= sess_nxt;
      cli_addr_r <= cli_addr_nxt;
      srv_addr_r <= srv_addr_nxt;
      cli_port_r <= cli_port_nxt;
      srv_port_r <= srv_port_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (s1_fin) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fin) begin
      o_status_r <= status;
      o_dir_r    <= dir;
      o_match_r  <= match;
      o_saddr_r  <= fields ? h_saddr_nxt : 32'd0;
      o_daddr_r  <= fields ? h_daddr_nxt : 32'd0;
      o_sport_r  <= fields ? h_sport_nxt : 16'd0;
      o_dport_r  <= fields ? h_dport_nxt : 16'd0;
      o_seq_r    <= fields ? h_seq_nxt : 32'd0;
      o_ack_r    <= fields ? h_ack_nxt : 32'd0;
      o_flags_r  <= fields ? h_flags_nxt : 8'd0;
      o_win_r    <= fields ? h_win_nxt : 16'd0;
      o_pay_r    <= payload;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_direction       = o_dir_r;
  assign out_in_session      = o_match_r;
  assign out_source_address  = o_saddr_r;
  assign out_dest_address    = o_daddr_r;
  assign out_source_port     = o_sport_r;
  assign out_dest_port       = o_dport_r;
  assign out_sequence_number = o_seq_r;
  assign out_ack_number      = o_ack_r;
  assign out_tcp_flag_bits   = o_flags_r;
  assign out_window_size     = o_win_r;
  assign out_payload_length  = o_pay_r;

`ifndef SYNTHESIS
  a_bad_status_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_direction == DIR_NONE && !out_in_session)
    else $error("direction or session set on a failed header");

  a_session_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_session |-> out_direction != DIR_NONE)
    else $error("session match without endpoint direction");

  a_short_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IP_SHORT || out_status == ST_TRUNC) |->
    out_source_address == 32'd0 && out_sequence_number == 32'd0 &&
    out_payload_length == 16'd0)
    else $error("header fields leak on short or truncated frame");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fin |=> pos_r == '0 && ihl_r == '0)
    else $error("frame state not cleared after final byte");

  a_session_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sess_r |=> sess_r)
    else $error("recorded session lost");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r)
    else $error("input stalled without a blocked final byte");
`endif

endmodule

[tb/sv/tb_tcp_header_slicer_with_session.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tcp_header_slicer_with_session
// Self-checking bench for the byte-stream TCP/IP header slicer.
// Frames are built from header descriptions (good, short, truncated, with
// options, overlapping, plus raw noise) and sent byte by byte with
// random bursts and gaps. A clocked tracker follows every accepted byte the way
// the block parses it and queues the expected header summary for each frame;
// the result side stalls on its own pattern and compares every field.
// Runs at several minimum-length settings, from zero up to the header maximum.
// ---------------------------------------------------------------------------
module tb_tcp_header_slicer_with_session;
  import tcpsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } wire_byte_t;

  typedef struct {
    status_t     status;
    dir_t        direction;
    logic        in_session;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flags;
    logic [15:0] window;
    logic [15:0] payload_len;
  } header_summary_t;

  typedef struct {
    int unsigned ihl;
    int unsigned off;
    int unsigned payload;
    int unsigned cut;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] win;
    logic [7:0]  flags;
  } frame_spec_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = CFG_MIN_IP;
  logic [REG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_data_byte = 8'h00;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [1:0]          out_direction;
  logic                out_in_session;
  logic [31:0]         out_source_address;
  logic [31:0]         out_dest_address;
  logic [15:0]         out_source_port;
  logic [15:0]         out_dest_port;
  logic [31:0]         out_sequence_number;
  logic [31:0]         out_ack_number;
  logic [7:0]          out_tcp_flag_bits;
  logic [15:0]         out_window_size;
  logic [15:0]         out_payload_length;

  tcp_header_slicer_with_session dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_direction       (out_direction),
    .out_in_session      (out_in_session),
    .out_source_address  (out_source_address),
    .out_dest_address    (out_dest_address),
    .out_source_port     (out_source_port),
    .out_dest_port       (out_dest_port),
    .out_sequence_number (out_sequence_number),
    .out_ack_number      (out_ack_number),
    .out_tcp_flag_bits   (out_tcp_flag_bits),
    .out_window_size     (out_window_size),
    .out_payload_length  (out_payload_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  wire_byte_t      wire_bytes[$];
  header_summary_t predicted_headers[$];

  // parse state tracked alongside the block
  int unsigned min_ip_len = MIN_IP_RESET;
  int unsigned min_tcp_len = MIN_TCP_RESET;
  int unsigned frame_pos = 0;
  logic [3:0]  ip_words = '0;
  logic [3:0]  tcp_words = '0;
  logic [31:0] cap_src = '0, cap_dst = '0, cap_seq = '0, cap_ack = '0;
  logic [15:0] cap_sport = '0, cap_dport = '0, cap_win = '0;
  logic [7:0]  cap_flags = '0;
  bit          session_set = 1'b0;
  logic [31:0] client_addr = '0, server_addr = '0;
  logic [15:0] client_port = '0, server_port = '0;

  logic [31:0] addr_pool[3];
  logic [15:0] port_pool[3];

  int unsigned err_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned frames_checked = 0;
  int unsigned status_hits[4] = '{0, 0, 0, 0};
  int unsigned dir_hits[3] = '{0, 0, 0};
  int unsigned session_hits = 0;
  int unsigned longest_payload = 0;
  int unsigned cycle_count = 0;

  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  wire_byte_t  next_byte;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  task automatic close_frame();
    header_summary_t want;
    int unsigned     ip_bytes, tcp_start, tcp_bytes;
    bit              show;
    ip_bytes  = 4 * ip_words;
    tcp_start = ETH_HEADER_BYTES + ip_bytes;
    tcp_bytes = 4 * tcp_words;
    show = 1'b0;
    want.status      = ST_OK;
    want.direction   = DIR_NONE;
    want.in_session  = 1'b0;
    want.src_addr    = '0;
    want.dst_addr    = '0;
    want.src_port    = '0;
    want.dst_port    = '0;
    want.seq_num     = '0;
    want.ack_num     = '0;
    want.flags       = '0;
    want.window      = '0;
    want.payload_len = '0;
    if (frame_pos <= ETH_HEADER_BYTES) begin
      want.status = ST_TRUNC;
    end else if (ip_bytes < min_ip_len) begin
      want.status = ST_IP_SHORT;
    end else if (frame_pos < tcp_start + FIXED_TCP_BYTES) begin
      want.status = ST_TRUNC;
    end else begin
      if (!session_set) begin
        client_addr = cap_src;
        server_addr = cap_dst;
        client_port = cap_sport;
        server_port = cap_dport;
        session_set = 1'b1;
      end
      if (tcp_bytes < min_tcp_len) begin
        want.status = ST_TCP_SHORT;
        show = 1'b1;
      end else if (frame_pos < tcp_start + tcp_bytes) begin
        want.status = ST_TRUNC;
      end else begin
        show = 1'b1;
        want.payload_len = 16'(frame_pos - tcp_start - tcp_bytes);
        if (cap_src == client_addr && cap_sport == client_port)
          want.direction = DIR_CLIENT;
        else if (cap_src == server_addr && cap_sport == server_port)
          want.direction = DIR_SERVER;
        want.in_session =
          (cap_src == client_addr && cap_sport == client_port &&
           cap_dst == server_addr && cap_dport == server_port) ||
          (cap_dst == client_addr && cap_dport == client_port &&
           cap_src == server_addr && cap_sport == server_port);
      end
    end
    if (show) begin
      want.src_addr = cap_src;
      want.dst_addr = cap_dst;
      want.src_port = cap_sport;
      want.dst_port = cap_dport;
      want.seq_num  = cap_seq;
      want.ack_num  = cap_ack;
      want.flags    = cap_flags;
      want.window   = cap_win;
    end
    predicted_headers.push_back(want);
    frame_pos = 0;
    ip_words  = '0;
    tcp_words = '0;
    cap_src   = '0;
    cap_dst   = '0;
    cap_sport = '0;
    cap_dport = '0;
    cap_seq   = '0;
    cap_ack   = '0;
    cap_flags = '0;
    cap_win   = '0;
  endtask

  task automatic track_byte(input logic [7:0] b, input logic fin);
    int unsigned p, r, tcp_start;
    p = frame_pos;
    if (p < MAX_FRAME_BYTES) begin
      if (p == ETH_HEADER_BYTES) ip_words = b[3:0];
      if (p >= ETH_HEADER_BYTES) begin
        r = p - ETH_HEADER_BYTES;
        if (r >= 12 && r <= 15) cap_src = {cap_src[23:0], b};
        if (r >= 16 && r <= 19) cap_dst = {cap_dst[23:0], b};
      end
      tcp_start = ETH_HEADER_BYTES + 4 * ip_words;
      if (p >= tcp_start) begin
        r = p - tcp_start;
        if (r <= 1) cap_sport = {cap_sport[7:0], b};
        else if (r <= 3) cap_dport = {cap_dport[7:0], b};
        else if (r <= 7) cap_seq = {cap_seq[23:0], b};
        else if (r <= 11) cap_ack = {cap_ack[23:0], b};
        else if (r == 12) tcp_words = b[7:4];
        else if (r == 13) cap_flags = b;
        else if (r <= 15) cap_win = {cap_win[7:0], b};
      end
      frame_pos = p + 1;
    end
    bytes_taken++;
    if (fin) close_frame();
  endtask

  task automatic queue_frame(input frame_spec_t s);
    logic [7:0]  img[];
    int unsigned tcp_start, full, total, n, k;
    tcp_start = ETH_HEADER_BYTES + 4 * s.ihl;
    full  = tcp_start + 4 * s.off + s.payload;
    total = full;
    if (total < 34) total = 34;
    if (total < tcp_start + 20) total = tcp_start + 20;
    img = new[total];
    foreach (img[i]) img[i] = 8'($urandom);
    for (k = 0; k < 4; k++) begin
      img[26 + k] = s.src[31 - 8 * k -: 8];
      img[30 + k] = s.dst[31 - 8 * k -: 8];
      img[tcp_start + 4 + k] = s.seq[31 - 8 * k -: 8];
      img[tcp_start + 8 + k] = s.ack[31 - 8 * k -: 8];
    end
    for (k = 0; k < 2; k++) begin
      img[tcp_start + k]      = s.sport[15 - 8 * k -: 8];
      img[tcp_start + 2 + k]  = s.dport[15 - 8 * k -: 8];
      img[tcp_start + 14 + k] = s.win[15 - 8 * k -: 8];
    end
    img[tcp_start + 12][7:4] = s.off[3:0];
    img[tcp_start + 13]      = s.flags;
    img[14][3:0]             = s.ihl[3:0];
    n = (s.cut != 0) ? s.cut : full;
    if (n > total) n = total;
    for (k = 0; k < n; k++) wire_bytes.push_back({img[k], k == n - 1});
  endtask

  function automatic frame_spec_t base_frame(input int unsigned src_i, input int unsigned dst_i);
    frame_spec_t s;
    s.ihl     = 5;
    s.off     = 5;
    s.payload = $urandom_range(0, 12);
    s.cut     = 0;
    s.src     = addr_pool[src_i];
    s.dst     = addr_pool[dst_i];
    s.sport   = port_pool[src_i];
    s.dport   = port_pool[dst_i];
    s.seq     = $urandom;
    s.ack     = $urandom;
    s.win     = 16'($urandom);
    s.flags   = 8'($urandom);
    return s;
  endfunction

  function automatic int unsigned pick_endpoint();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return 1;
    if (r < 9) return 2;
    return 3;
  endfunction

  task automatic queue_random_frame();
    frame_spec_t s;
    int unsigned roll, si, di, n, k;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      n = $urandom_range(1, 70);
      for (k = 0; k < n; k++) wire_bytes.push_back({8'($urandom), k == n - 1});
    end else begin
      si = pick_endpoint();
      di = pick_endpoint();
      s = base_frame(si % 3, di % 3);
      if (si == 3) begin
        s.src   = $urandom;
        s.sport = 16'($urandom);
      end
      if (di == 3) begin
        s.dst   = $urandom;
        s.dport = 16'($urandom);
      end
      if ($urandom_range(0, 3) == 0) s.ihl = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) s.off = $urandom_range(0, 15);
      s.payload = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 24);
      if (roll < 25)
        s.cut = $urandom_range(1, ETH_HEADER_BYTES + 4 * s.ihl + 4 * s.off + s.payload);
      queue_frame(s);
    end
  endtask

  task automatic queue_random_run(input int unsigned min_bytes, input int unsigned min_frames);
    int unsigned frames;
    frames = 0;
    while (wire_bytes.size() < min_bytes || frames < min_frames) begin
      queue_random_frame();
      frames++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (wire_bytes.size() != 0 || in_valid || predicted_headers.size() != 0);
  endtask

  task automatic set_min_lengths(input int unsigned ip_len, input int unsigned tcp_len);
    repeat (4) @(posedge clk);
    cfg_index   <= CFG_MIN_IP;
    cfg_wr_data <= REG_W'(ip_len);
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_index   <= CFG_MIN_TCP;
    cfg_wr_data <= REG_W'(tcp_len);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    min_ip_len  = ip_len;
    min_tcp_len = tcp_len;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: frame %0d %s expected %0h actual %0h",
               $time, frames_checked, name, want_v, got_v);
      err_count++;
    end
  endtask

  // sender: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_byte(in_data_byte, in_last_byte);
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (wire_bytes.size() != 0) begin
        next_byte = wire_bytes.pop_front();
        in_data_byte <= next_byte.data;
        in_last_byte <= next_byte.fin;
        in_valid     <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    header_summary_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_headers.size() == 0) begin
        $display("%0t ns: result with no frame pending, expected none actual status %0d",
                 $time, out_status);
        err_count++;
      end else begin
        want = predicted_headers.pop_front();
        check_field("status", want.status, out_status);
        check_field("direction", want.direction, out_direction);
        check_field("in_session", want.in_session, out_in_session);
        check_field("source_address", want.src_addr, out_source_address);
        check_field("dest_address", want.dst_addr, out_dest_address);
        check_field("source_port", want.src_port, out_source_port);
        check_field("dest_port", want.dst_port, out_dest_port);
        check_field("sequence_number", want.seq_num, out_sequence_number);
        check_field("ack_number", want.ack_num, out_ack_number);
        check_field("tcp_flag_bits", want.flags, out_tcp_flag_bits);
        check_field("window_size", want.window, out_window_size);
        check_field("payload_length", want.payload_len, out_payload_length);
        status_hits[want.status]++;
        dir_hits[want.direction]++;
        if (want.in_session) session_hits++;
        if (want.payload_len > longest_payload) longest_payload = want.payload_len;
        frames_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, predicted_headers.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    frame_spec_t s;
    foreach (addr_pool[i]) begin
      addr_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default settings: session setup, directions, extremes, error paths
    s = base_frame(0, 1);
    s.payload = 5;
    queue_frame(s);
    s = base_frame(1, 0);
    s.payload = 0;
    s.seq     = '1;
    s.ack     = '0;
    s.flags   = '1;
    s.win     = '1;
    queue_frame(s);
    queue_frame(base_frame(0, 2));
    queue_frame(base_frame(2, 1));
    s = base_frame(0, 1);
    s.src   = '0;
    s.dst   = '0;
    s.sport = '0;
    s.dport = '0;
    s.seq   = '0;
    s.flags = '0;
    s.win   = '0;
    queue_frame(s);
    s = base_frame(0, 1);
    s.src   = '1;
    s.dst   = '1;
    s.sport = '1;
    s.dport = '1;
    s.ack   = '1;
    queue_frame(s);
    s = base_frame(0, 1);
    s.cut = 1;
    queue_frame(s);
    s.cut = ETH_HEADER_BYTES;
    queue_frame(s);
    s.cut = ETH_HEADER_BYTES + 1;
    queue_frame(s);
    s = base_frame(0, 1);
    s.ihl = 2;
    queue_frame(s);
    s = base_frame(1, 0);
    s.off = 4;
    queue_frame(s);
    s = base_frame(0, 1);
    s.off = 8;
    s.cut = ETH_HEADER_BYTES + 20 + 25;
    queue_frame(s);
    s = base_frame(1, 0);
    s.cut = ETH_HEADER_BYTES + 20 + 19;
    queue_frame(s);
    wait_idle();

    // overlapping headers with no minimum
    set_min_lengths(0, 0);
    s = base_frame(0, 1);
    s.ihl     = 0;
    s.off     = 0;
    s.payload = 7;
    queue_frame(s);
    s = base_frame(1, 0);
    s.ihl = 1;
    s.off = 1;
    queue_frame(s);
    s = base_frame(0, 1);
    s.ihl = 3;
    s.off = 2;
    s.cut = $urandom_range(15, 40);
    queue_frame(s);
    s = base_frame(0, 2);
    s.ihl     = 0;
    s.off     = 0;
    s.payload = 0;
    queue_frame(s);
    wait_idle();

    // minimums at the largest header length
    set_min_lengths(60, 60);
    s = base_frame(0, 1);
    s.ihl     = 15;
    s.off     = 15;
    s.payload = 0;
    queue_frame(s);
    s.ihl = 14;
    s.cut = ETH_HEADER_BYTES + 1;
    queue_frame(s);
    s.ihl = 15;
    s.off = 14;
    s.cut = ETH_HEADER_BYTES + 60 + 20;
    queue_frame(s);
    wait_idle();

    set_min_lengths($urandom_range(0, 24), $urandom_range(0, 24));
    queue_random_run(30, 1);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    set_min_lengths(20, 20);
    queue_random_run(30, 1);
    hold_request = 1'b1;
    queue_random_run(90, 1);
    wait_idle();

    set_min_lengths($urandom_range(0, 60), $urandom_range(0, 60));
    queue_random_run(30, 1);
    wait_idle();

    set_min_lengths(MIN_IP_RESET, MIN_TCP_RESET);
    queue_random_run(30, 1);
    wait_idle();

    repeat (10) @(posedge clk);
    $display("Covered %0d bytes, %0d frames: ok %0d, ip short %0d, tcp short %0d, trunc %0d",
             bytes_taken, frames_checked, status_hits[ST_OK], status_hits[ST_IP_SHORT],
             status_hits[ST_TCP_SHORT], status_hits[ST_TRUNC]);
    $display("Client %0d, server %0d, neither %0d, session hits %0d, longest payload %0d",
             dir_hits[DIR_CLIENT], dir_hits[DIR_SERVER], dir_hits[DIR_NONE],
             session_hits, longest_payload);
    if (err_count == 0 && predicted_headers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
design/tcpsl_pkg.sv
design/tcp_header_slicer_with_session.sv
tb/sv/tb_tcp_header_slicer_with_session.sv
